// ----- sv/skx_pkg.sv -----
package skx_pkg;

   localparam int unsigned KEY_WORDS    = 7;
   localparam int unsigned CSR_COUNT    = 8;
   localparam int unsigned CSR_IDX_W    = 3;
   localparam int unsigned DIGEST_BYTES = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_COUNTER_START = 3'd7;

   localparam logic [31:0] H0_INIT = 32'h67452301;
   localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
   localparam logic [31:0] H2_INIT = 32'h98BADCFE;
   localparam logic [31:0] H3_INIT = 32'h10325476;
   localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   localparam logic [31:0] PAD_FIRST = 32'h80000000;
   localparam logic [31:0] PAD_LEN   = 32'h00000200;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_ROUND,
      ENG_ADD
   } eng_state_type;

   // Item handed from the front to the back through the queue.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       fresh;
      logic [4:0] pos;
      logic [63:0] counter;
   } work_type;

   function automatic logic [31:0] rotl1(input logic [31:0] x);
      rotl1 = {x[30:0], x[31]};
   endfunction

   function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      if (r < 7'd20) begin
         round_f = (b & c) | (~b & d);
      end else if (r < 7'd40) begin
         round_f = b ^ c ^ d;
      end else if (r < 7'd60) begin
         round_f = (b & c) | (b & d) | (c & d);
      end else begin
         round_f = b ^ c ^ d;
      end
   endfunction

   function automatic logic [31:0] round_k(input logic [6:0] r);
      if (r < 7'd20) begin
         round_k = K0;
      end else if (r < 7'd40) begin
         round_k = K1;
      end else if (r < 7'd60) begin
         round_k = K2;
      end else begin
         round_k = K3;
      end
   endfunction

endpackage

// ----- sv/skx_if.sv -----
interface skx_if #(parameter int unsigned WIDTH = 8) (input logic clock);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   logic             last;

   modport source (output valid, output data, output last, input ready);
   modport sink (input valid, input data, input last, output ready);
endinterface

// ----- sv/skx_front.sv -----
module skx_front #(
   parameter int unsigned BYTES_PER_BLOCK = 16
) (
   input  logic                clock,
   input  logic                reset,
   skx_if.sink                 req,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [63:0]         csr_data,
   output skx_pkg::work_type   work,
   output logic                work_valid,
   input  logic                work_ready
);
   localparam int unsigned USED = (BYTES_PER_BLOCK < skx_pkg::DIGEST_BYTES) ?
                                  BYTES_PER_BLOCK : skx_pkg::DIGEST_BYTES;

   logic [63:0] start_ff;
   logic [63:0] counter_ff, counter_in;
   logic [4:0]  pos_ff, pos_in;
   logic        take;

   assign req.ready  = work_ready;
   assign work_valid = req.valid;
   assign take       = req.valid && work_ready;

   always_comb begin
      work.data    = req.data;
      work.last    = req.last;
      work.fresh   = (pos_ff == 5'd0);
      work.pos     = pos_ff;
      work.counter = counter_ff;
   end

   always_comb begin
      counter_in = counter_ff;
      pos_in     = pos_ff;
      if (take) begin
         if (pos_ff == 5'(USED - 1)) begin
            pos_in     = 5'd0;
            counter_in = counter_ff + 64'd1;
         end else begin
            pos_in = pos_ff + 5'd1;
         end
         if (req.last) begin
            pos_in     = 5'd0;
            counter_in = start_ff;
         end
      end
      if (csr_write && csr_index == skx_pkg::CSR_COUNTER_START) begin
         pos_in     = 5'd0;
         counter_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= '0;
         counter_ff <= '0;
         pos_ff     <= '0;
      end else begin
         counter_ff <= counter_in;
         pos_ff     <= pos_in;
         if (csr_write && csr_index == skx_pkg::CSR_COUNTER_START) begin
            start_ff <= csr_data;
         end
      end
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff < 5'(USED)) else $error("byte position out of range");
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      take && req.last && !csr_write |=> pos_ff == 5'd0) else $error("last not honored");
   a_wrap: assert property (@(posedge clock) disable iff (reset)
      take && !req.last && !csr_write && pos_ff == 5'(USED - 1) |=>
      counter_ff == $past(counter_ff) + 64'd1) else $error("counter step lost");
endmodule

// ----- sv/skx_queue.sv -----
module skx_queue (
   input  logic              clock,
   input  logic              reset,
   input  skx_pkg::work_type in_work,
   input  logic              in_valid,
   output logic              in_ready,
   output skx_pkg::work_type out_work,
   output logic              out_valid,
   input  logic              out_ready
);
   skx_pkg::work_type slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       rd_ff, wr_ff;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_work  = slot_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= in_work;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
      end
   end

   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("queue overfilled");
   a_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) == (rd_ff != wr_ff)) else $error("queue pointers out of step");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid) else $error("queue lost entry");
endmodule

// ----- sv/skx_back.sv -----
module skx_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [63:0]       key_word [skx_pkg::KEY_WORDS],
   input  skx_pkg::work_type work,
   input  logic              work_valid,
   output logic              work_ready,
   skx_if.source             rsp
);
   skx_pkg::eng_state_type state_ff, state_in;
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  h_ff [5];
   logic [31:0]  w_ff [16];
   logic [6:0]   round_ff;
   logic         second_ff;
   logic [159:0] ks_ff;
   logic         out_valid_ff;
   logic [7:0]   out_byte_ff;
   logic         out_last_ff;
   logic         start, emit, out_free, round_last;
   logic [31:0]  wnext, t_val;
   logic [7:0]   ks_byte;

   assign out_free   = !out_valid_ff || rsp.ready;
   assign start      = work_valid && work.fresh && out_free;
   assign round_last = (round_ff == 7'd79);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         skx_pkg::ENG_IDLE:  if (start) state_in = skx_pkg::ENG_ROUND;
         skx_pkg::ENG_ROUND: if (round_last) state_in = skx_pkg::ENG_ADD;
         skx_pkg::ENG_ADD:   state_in = second_ff ? skx_pkg::ENG_IDLE : skx_pkg::ENG_ROUND;
         default:            state_in = skx_pkg::ENG_IDLE;
      endcase
   end

   always_comb begin
      emit = 1'b0;
      unique case (state_ff)
         skx_pkg::ENG_IDLE: emit = work_valid && !work.fresh && out_free;
         skx_pkg::ENG_ADD:  emit = second_ff && out_free;
         default:           emit = 1'b0;
      endcase
   end
   assign work_ready = emit;

   assign wnext = skx_pkg::rotl1(w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0]);
   assign t_val = {a_ff[26:0], a_ff[31:27]} + skx_pkg::round_f(round_ff, b_ff, c_ff, d_ff)
                  + e_ff + w_ff[0] + skx_pkg::round_k(round_ff);

   always_comb begin
      logic [159:0] ks;
      ks = (state_ff == skx_pkg::ENG_ADD) ?
           {h_ff[0] + a_ff, h_ff[1] + b_ff, h_ff[2] + c_ff, h_ff[3] + d_ff, h_ff[4] + e_ff}
           : ks_ff;
      ks_byte = ks[159 - 8 * work.pos -: 8];
   end

   always_ff @(posedge clock) begin
      if (state_ff == skx_pkg::ENG_IDLE && start) begin
         h_ff[0] <= skx_pkg::H0_INIT; h_ff[1] <= skx_pkg::H1_INIT;
         h_ff[2] <= skx_pkg::H2_INIT; h_ff[3] <= skx_pkg::H3_INIT;
         h_ff[4] <= skx_pkg::H4_INIT;
         a_ff <= skx_pkg::H0_INIT; b_ff <= skx_pkg::H1_INIT; c_ff <= skx_pkg::H2_INIT;
         d_ff <= skx_pkg::H3_INIT; e_ff <= skx_pkg::H4_INIT;
         for (int i = 0; i < 7; i++) begin
            w_ff[2 * i]     <= key_word[i][63:32];
            w_ff[2 * i + 1] <= key_word[i][31:0];
         end
         w_ff[14] <= work.counter[63:32];
         w_ff[15] <= work.counter[31:0];
         round_ff  <= '0;
         second_ff <= 1'b0;
      end else if (state_ff == skx_pkg::ENG_ROUND) begin
         e_ff <= d_ff; d_ff <= c_ff; c_ff <= {b_ff[1:0], b_ff[31:2]};
         b_ff <= a_ff; a_ff <= t_val;
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= wnext;
         round_ff <= round_ff + 7'd1;
      end else if (state_ff == skx_pkg::ENG_ADD) begin
         h_ff[0] <= h_ff[0] + a_ff; h_ff[1] <= h_ff[1] + b_ff;
         h_ff[2] <= h_ff[2] + c_ff; h_ff[3] <= h_ff[3] + d_ff;
         h_ff[4] <= h_ff[4] + e_ff;
         a_ff <= h_ff[0] + a_ff; b_ff <= h_ff[1] + b_ff; c_ff <= h_ff[2] + c_ff;
         d_ff <= h_ff[3] + d_ff; e_ff <= h_ff[4] + e_ff;
         ks_ff <= {h_ff[0] + a_ff, h_ff[1] + b_ff, h_ff[2] + c_ff, h_ff[3] + d_ff,
                   h_ff[4] + e_ff};
         w_ff[0] <= skx_pkg::PAD_FIRST;
         for (int i = 1; i < 15; i++) w_ff[i] <= '0;
         w_ff[15] <= skx_pkg::PAD_LEN;
         round_ff  <= '0;
         second_ff <= 1'b1;
      end
      if (emit) begin
         out_byte_ff <= work.data ^ ks_byte;
         out_last_ff <= work.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skx_pkg::ENG_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_byte_ff;
   assign rsp.last  = out_last_ff;

   a_round_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == skx_pkg::ENG_ROUND |-> round_ff <= 7'd79) else $error("round overrun");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free) else $error("result overwritten");
   a_second_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == skx_pkg::ENG_ADD && second_ff |=> state_ff == skx_pkg::ENG_IDLE)
      else $error("engine did not finish");
endmodule

// ----- sv/sha1_counter_keystream_xor.sv -----
// Path: a byte that starts a keystream block passes through the queue, then two 80-round
// SHA-1 compressions at one round per cycle, each followed by a finalize step, before its
// result is registered; other bytes pass through the queue and the output register.
// Throughput: one byte per cycle within a block while the output is not stalled; bytes of
// the next block wait in the queue for the single shared round unit.
// Reset (synchronous, active high) clears the key, the counter, the queue and the engine.
module sha1_counter_keystream_xor #(
   parameter int unsigned BYTES_PER_BLOCK = 16
) (
   input  logic        clock,
   input  logic        reset,
   skx_if.sink         req,
   skx_if.source       rsp,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   logic [63:0] key_ff [skx_pkg::KEY_WORDS];
   skx_pkg::work_type f_work, q_work;
   logic f_valid, f_ready, q_valid, q_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 7; i++) key_ff[i] <= '0;
      end else if (csr_write && csr_index != skx_pkg::CSR_COUNTER_START) begin
         key_ff[csr_index] <= csr_data;
      end
   end

   skx_front #(.BYTES_PER_BLOCK(BYTES_PER_BLOCK)) u_front (
      .clock, .reset, .req, .csr_write, .csr_index, .csr_data,
      .work(f_work), .work_valid(f_valid), .work_ready(f_ready));

   skx_queue u_queue (
      .clock, .reset, .in_work(f_work), .in_valid(f_valid), .in_ready(f_ready),
      .out_work(q_work), .out_valid(q_valid), .out_ready(q_ready));

   skx_back u_back (
      .clock, .reset, .key_word(key_ff), .work(q_work), .work_valid(q_valid),
      .work_ready(q_ready), .rsp);
endmodule
